// ----- hdl/pqh_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the heap queue.
package pqh_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam int IN_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = VALUE_WIDTH + CNT_W + 1 + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} op_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start_push;
		logic start_pop;
		logic load_last;
		logic up_read;
		logic up_step;
		logic dn_read;
		logic dn_step;
		logic result_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic count_one;
		logic up_done;
		logic dn_done;
	} dp_stat_t;

endpackage

// ----- hdl/pqh_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module pqh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                         rdata_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- hdl/pqh_dp.sv -----
// Heap datapath: element store, count, sift registers, order bit and result register.
module pqh_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic                                 cfg_wr_data,
	input  logic                                 cmd,
	input  logic signed [pqh_pkg::VALUE_WIDTH-1:0] value,
	input  pqh_pkg::dp_cmd_t                     ctl,
	output pqh_pkg::dp_stat_t                    stat,
	output logic signed [pqh_pkg::VALUE_WIDTH-1:0] top_value,
	output logic [pqh_pkg::CNT_W-1:0]            item_count,
	output logic                                 empty_flag,
	output pqh_pkg::op_status_t                  op_status
);

	localparam int CHILD_W = pqh_pkg::IDX_W + 2;

	logic                                   order_q;
	logic [pqh_pkg::CNT_W-1:0]              count_q;
	logic [pqh_pkg::IDX_W-1:0]              idx_q;
	logic signed [pqh_pkg::VALUE_WIDTH-1:0] cur_q;
	logic signed [pqh_pkg::VALUE_WIDTH-1:0] root_q;
	pqh_pkg::op_status_t                    status_q;

	logic [pqh_pkg::IDX_W-1:0]              raddr_a, raddr_b, waddr, parent_idx;
	logic [pqh_pkg::CNT_W-1:0]              cnt_dec;
	logic signed [pqh_pkg::VALUE_WIDTH-1:0] rd_a, rd_b, wdata, best_v;
	logic                                   we;
	logic [CHILD_W-1:0]                     l_full, r_full, cnt_ext;
	logic                                   use_l, use_r, up_move;

	function automatic logic above(input logic ord,
	                               input logic signed [pqh_pkg::VALUE_WIDTH-1:0] a,
	                               input logic signed [pqh_pkg::VALUE_WIDTH-1:0] b);
		return ord ? (a > b) : (a < b);
	endfunction

	pqh_ram #(
		.WIDTH(pqh_pkg::VALUE_WIDTH),
		.DEPTH(pqh_pkg::CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rd_a),
		.raddr_b(raddr_b),
		.rdata_b(rd_b)
	);

	always_comb begin
		cnt_dec    = count_q - pqh_pkg::CNT_W'(1);
		parent_idx = (idx_q - pqh_pkg::IDX_W'(1)) >> 1;
		l_full     = {1'b0, idx_q, 1'b1};
		r_full     = l_full + CHILD_W'(1);
		cnt_ext    = CHILD_W'(count_q);

		up_move = (idx_q != '0) && above(order_q, cur_q, rd_a);

		// Strict compares keep the left child on ties.
		use_l  = (l_full < cnt_ext) && above(order_q, rd_a, cur_q);
		best_v = use_l ? rd_a : cur_q;
		use_r  = (r_full < cnt_ext) && above(order_q, rd_b, best_v);

		if (ctl.start_pop) begin
			raddr_a = cnt_dec[pqh_pkg::IDX_W-1:0];
		end else if (ctl.up_read) begin
			raddr_a = parent_idx;
		end else begin
			raddr_a = l_full[pqh_pkg::IDX_W-1:0];
		end
		raddr_b = r_full[pqh_pkg::IDX_W-1:0];

		we    = ctl.up_step || ctl.dn_step;
		waddr = idx_q;
		if (ctl.up_step) begin
			wdata = up_move ? rd_a : cur_q;
		end else if (use_r) begin
			wdata = rd_b;
		end else if (use_l) begin
			wdata = rd_a;
		end else begin
			wdata = cur_q;
		end

		stat.full      = (count_q == pqh_pkg::CNT_W'(pqh_pkg::CAPACITY));
		stat.empty     = (count_q == '0);
		stat.count_one = (count_q == pqh_pkg::CNT_W'(1));
		stat.up_done   = !up_move;
		stat.dn_done   = !use_l && !use_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			if (ctl.start_push) begin
				count_q <= count_q + pqh_pkg::CNT_W'(1);
			end else if (ctl.start_pop) begin
				count_q <= cnt_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			if (cmd == pqh_pkg::CMD_PUSH && stat.full) begin
				status_q <= pqh_pkg::ST_FULL;
			end else if (cmd == pqh_pkg::CMD_POP && stat.empty) begin
				status_q <= pqh_pkg::ST_EMPTY;
			end else begin
				status_q <= pqh_pkg::ST_OK;
			end
		end
		if (ctl.start_push) begin
			cur_q <= value;
			idx_q <= count_q[pqh_pkg::IDX_W-1:0];
		end else if (ctl.start_pop) begin
			idx_q <= '0;
		end else if (ctl.up_step && up_move) begin
			idx_q <= parent_idx;
		end else if (ctl.dn_step && !stat.dn_done) begin
			idx_q <= use_r ? r_full[pqh_pkg::IDX_W-1:0] : l_full[pqh_pkg::IDX_W-1:0];
		end
		if (ctl.load_last) begin
			cur_q <= rd_a;
		end
		// Mirror entry zero so the top is at hand without a read.
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		if (ctl.result_load) begin
			top_value  <= stat.empty ? '0 : root_q;
			item_count <= count_q;
			empty_flag <= stat.empty;
			op_status  <= status_q;
		end
	end

endmodule

// ----- hdl/pqh_ctrl.sv -----
// Heap controller: sequences push sift-up, pop sift-down and the result handoff.
module pqh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              cmd,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pqh_pkg::dp_stat_t stat,
	output pqh_pkg::dp_cmd_t  ctl
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_UP_RD   = 7'b0000010,
		S_UP_CMP  = 7'b0000100,
		S_DN_LOAD = 7'b0001000,
		S_DN_RD   = 7'b0010000,
		S_DN_CMP  = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.accept = 1'b1;
					if (cmd == pqh_pkg::CMD_PUSH) begin
						if (stat.full) begin
							state_d = S_FINISH;
						end else begin
							ctl.start_push = 1'b1;
							state_d        = S_UP_RD;
						end
					end else if (stat.empty) begin
						state_d = S_FINISH;
					end else begin
						ctl.start_pop = 1'b1;
						state_d       = stat.count_one ? S_FINISH : S_DN_LOAD;
					end
				end
			end
			S_UP_RD: begin
				ctl.up_read = 1'b1;
				state_d     = S_UP_CMP;
			end
			S_UP_CMP: begin
				ctl.up_step = 1'b1;
				state_d     = stat.up_done ? S_FINISH : S_UP_RD;
			end
			S_DN_LOAD: begin
				ctl.load_last = 1'b1;
				ctl.dn_read   = 1'b1;
				state_d       = S_DN_CMP;
			end
			S_DN_RD: begin
				ctl.dn_read = 1'b1;
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				ctl.dn_step = 1'b1;
				state_d     = stat.dn_done ? S_FINISH : S_DN_RD;
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					ctl.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/priority_queue_heap.sv -----
// Top level of the bounded binary-heap priority queue of signed values.
//
// Each input request is a push of s_tdata (s_tuser = 0) or a pop of the top
// (s_tuser = 1); each returns exactly one result with the new top (0 when
// empty), the element count, an empty flag and a status code (ok, push
// dropped because full, pop on empty ignored). cfg_wr_data selects the order
// (0 smallest on top, 1 largest on top); write it only while idle. One request
// is worked on at a time. A push does a parent read and a compare/write for
// each level the value climbs (at most 6 at capacity 64); a pop loads the
// last element and does a child read and a compare/write for each level it
// sinks (at most 5 at capacity 64). A pop that empties the heap and any
// rejected request go straight to the result. The next request is accepted in
// the cycle after its result is loaded. Reads of the store RAM are registered.
// A new request is accepted while a finished result still waits in the output
// register; the request after it holds in its last cycle until the receiver
// takes the waiting result.
module priority_queue_heap (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] value
	input  logic [pqh_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] cmd
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] top_value, [38:32] item_count, [39] empty_flag, [41:40] op_status,
	// [47:42] zero
	output logic [pqh_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int PAD_W = pqh_pkg::OUT_TDATA_W - pqh_pkg::OUT_FIELDS_W;

	pqh_pkg::dp_cmd_t                       ctl;
	pqh_pkg::dp_stat_t                      stat;
	logic signed [pqh_pkg::VALUE_WIDTH-1:0] top_value;
	logic [pqh_pkg::CNT_W-1:0]              item_count;
	logic                                   empty_flag;
	pqh_pkg::op_status_t                    op_status;

	// Sequence the work of each request.
	pqh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	// Hold the store, the count and the result payload.
	pqh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (s_tuser),
		.value      (s_tdata[pqh_pkg::VALUE_WIDTH-1:0]),
		.ctl        (ctl),
		.stat       (stat),
		.top_value  (top_value),
		.item_count (item_count),
		.empty_flag (empty_flag),
		.op_status  (op_status)
	);

	// Pack the result fields, lowest field first, zero padded to bytes.
	assign m_tdata = {{PAD_W{1'b0}}, op_status, empty_flag, item_count, top_value};

	// Only one request is in flight: ready drops right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// A push never starts on a full heap.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_push |-> !stat.full)
		else $error("push started on a full heap");

	// A pop never starts on an empty heap.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_pop |-> !stat.empty)
		else $error("pop started on an empty heap");

	// A loaded result is presented and its empty flag matches the count.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.result_load |=> (m_tvalid && (empty_flag == stat.empty)))
		else $error("result not presented or empty flag inconsistent");

endmodule
